>>> hw/rtl/scsi_cdb_analyzer_defines.svh
// Assertion macros for the SCSI CDB analyzer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SCSI_CDB_ANALYZER_DEFINES_SVH
`define SCSI_CDB_ANALYZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SCA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sca_pkg.sv
// Shared types, opcodes and lookup functions for the SCSI CDB analyzer.
// No dependencies; used by all analyzer modules and the checker.
`default_nettype none

package sca_pkg;

   // opcodes with special handling
   localparam logic [7:0] OP_FORMAT_UNIT   = 8'h04;
   localparam logic [7:0] OP_FORMAT_TRACK  = 8'h06;
   localparam logic [7:0] OP_READ6         = 8'h08;
   localparam logic [7:0] OP_WRITE6        = 8'h0a;
   localparam logic [7:0] OP_SASI_INIT     = 8'h0c;
   localparam logic [7:0] OP_WRITE_BUFFER  = 8'h0f;
   localparam logic [7:0] OP_MODE_SELECT6  = 8'h15;
   localparam logic [7:0] OP_READ10        = 8'h28;
   localparam logic [7:0] OP_WRITE10       = 8'h2a;
   localparam logic [7:0] OP_VERIFY        = 8'h2f;
   localparam logic [7:0] OP_MODE_SELECT10 = 8'h55;
   localparam logic [7:0] OP_READ12        = 8'ha8;
   localparam logic [7:0] OP_WRITE12       = 8'haa;
   localparam logic [7:0] OP_READ_CD_MSF   = 8'hb9;
   localparam logic [7:0] OP_READ_CD       = 8'hbe;

   // configuration register indexes
   localparam logic [1:0] CSR_DEVICE_IS_CD  = 2'd0;
   localparam logic [1:0] CSR_BLOCK_SIZE    = 2'd1;
   localparam logic [1:0] CSR_LEGACY_ANSI   = 2'd2;
   localparam logic [1:0] CSR_SASI_ALLOWED  = 2'd3;

   localparam int          CSR_DATA_W       = 17;
   localparam logic [16:0] BLOCK_SIZE_RESET = 17'd512;

   // transfer direction codes
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_OUT  = 2'd1;
   localparam logic [1:0] DIR_IN   = 2'd2;

   localparam logic [2:0]  SENSE_ILLEGAL_REQUEST = 3'd5;
   localparam logic [5:0]  ASC_ILLEGAL_FIELD     = 6'h24;
   localparam logic [16:0] CD_RAW_BLOCK          = 17'd2448;  // 2352 data + 96 subchannel
   localparam logic [31:0] SASI_INIT_LENGTH      = 32'd8;
   localparam logic [4:0]  LONGEST_LEGACY_CDB    = 5'd10;

   localparam logic [4:0] CDB_LEN6  = 5'd6;
   localparam logic [4:0] CDB_LEN10 = 5'd10;
   localparam logic [4:0] CDB_LEN12 = 5'd12;
   localparam logic [4:0] CDB_LEN16 = 5'd16;

   typedef struct packed {
      logic        device_is_cd;
      logic [16:0] block_size;
      logic        legacy_ansi;
      logic        sasi_commands_allowed;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  command;
      logic [7:0]  cdb_byte1;
      logic [7:0]  cdb_byte4;
      logic [7:0]  cdb_byte6;
      logic [7:0]  cdb_byte7;
      logic [7:0]  cdb_byte8;
      logic [7:0]  cdb_byte9;
      logic [31:0] preset_length;
   } req_type;

   // decoded command, handed from the decoder to the scaler
   typedef struct packed {
      logic        reject;
      logic [4:0]  cdb_length;
      logic [1:0]  direction;
      logic        direction_unknown;
      logic [31:0] data_length;
      logic        dlen_from_prod;
      logic        bneed_from_prod;
      logic [31:0] mul_a;
      logic [16:0] mul_b;
   } dec_type;

   typedef struct packed {
      logic        accepted;
      logic        status;
      logic [4:0]  cdb_length;
      logic [1:0]  direction;
      logic        direction_unknown;
      logic [31:0] data_length;
      logic [31:0] buffer_need;
      logic [2:0]  sense_key;
      logic [5:0]  sense_code;
   } rsp_type;

   typedef struct packed {
      logic [1:0] direction;
      logic       unknown;
   } dir_info_type;

   function automatic logic [4:0] group_length(input logic [2:0] group);
      logic [4:0] len;
      unique case (group)
         3'd0:    len = CDB_LEN6;
         3'd1:    len = CDB_LEN10;
         3'd2:    len = CDB_LEN10;
         3'd3:    len = CDB_LEN12;
         3'd4:    len = CDB_LEN16;
         3'd5:    len = CDB_LEN12;
         3'd6:    len = CDB_LEN10;
         default: len = CDB_LEN6;
      endcase
      return len;
   endfunction

   function automatic dir_info_type dir_lookup(input logic [7:0] op);
      dir_info_type info;
      info.direction = DIR_NONE;
      info.unknown   = 1'b0;
      unique case (op) inside
         8'h04, 8'h0a, 8'h0c, 8'h2a, 8'haa, 8'h15, 8'h55, 8'h0f:
            info.direction = DIR_OUT;
         8'h01, 8'h03, 8'h08, 8'h12, 8'h1a, 8'h5a, 8'h25, 8'h28, 8'h34,
         8'h37, 8'h42, 8'h43, 8'ha8, 8'h51, 8'h52, 8'hb9, 8'hbd, 8'hbe:
            info.direction = DIR_IN;
         8'h00, 8'h05, 8'h06, 8'h09, 8'h0b, 8'h11, 8'h16, 8'h17, 8'h19,
         8'h1b, 8'h1d, 8'h1e, 8'h2b, 8'h35, 8'h45, 8'h47, 8'h48, 8'h49,
         8'h4b, 8'h4e, 8'ha5, 8'ha9, 8'hba, 8'hbc, 8'he0, 8'he3, 8'he4:
            info.direction = DIR_NONE;
         default:
            info.unknown = 1'b1;
      endcase
      return info;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sca_decoder.sv
// Opcode decode for the SCSI CDB analyzer: legality, direction, lengths and
// multiplier operands. Depends on sca_pkg.
`default_nettype none

module sca_decoder (
   input  wire sca_pkg::req_type cmd,
   input  wire sca_pkg::cfg_type cfg,
   output sca_pkg::dec_type      dec
);

   logic [8:0]  c6;
   logic [15:0] c10;
   logic [31:0] c12;
   logic [4:0]  clen;
   logic        reject;
   logic        fixed;
   logic        len_set;
   logic [1:0]  fixed_dir;
   logic [31:0] set_len;
   logic        dlen_prod;
   logic        bneed_prod;
   logic [31:0] mul_a;
   logic [16:0] mul_b;
   sca_pkg::dir_info_type dir_info;

   assign c6   = (cmd.cdb_byte4 == 8'd0) ? 9'd256 : {1'b0, cmd.cdb_byte4};
   assign c10  = {cmd.cdb_byte7, cmd.cdb_byte8};
   assign c12  = {cmd.cdb_byte6, cmd.cdb_byte7, cmd.cdb_byte8, cmd.cdb_byte9};
   assign clen = sca_pkg::group_length(cmd.command[7:5]);
   assign dir_info = sca_pkg::dir_lookup(cmd.command);

   always_comb begin
      reject     = 1'b0;
      fixed      = 1'b0;
      len_set    = 1'b0;
      fixed_dir  = sca_pkg::DIR_NONE;
      set_len    = '0;
      dlen_prod  = 1'b0;
      bneed_prod = 1'b0;
      mul_a      = '0;
      mul_b      = cfg.block_size;
      if (cfg.legacy_ansi && (clen > sca_pkg::LONGEST_LEGACY_CDB)) begin
         reject = 1'b1;
      end else begin
         unique case (cmd.command) inside
            sca_pkg::OP_FORMAT_UNIT: begin
               if (cfg.device_is_cd) begin
                  reject = 1'b1;
               end else if (!cmd.cdb_byte1[4]) begin
                  fixed = 1'b1;
               end
            end
            sca_pkg::OP_FORMAT_TRACK: begin
               if (cfg.device_is_cd) reject = 1'b1;
               else fixed = 1'b1;
            end
            sca_pkg::OP_SASI_INIT: begin
               if (!cfg.sasi_commands_allowed) begin
                  reject = 1'b1;
               end else begin
                  len_set = 1'b1;
                  set_len = sca_pkg::SASI_INIT_LENGTH;
               end
            end
            sca_pkg::OP_READ6: begin
               mul_a      = {23'd0, c6};
               bneed_prod = 1'b1;
            end
            sca_pkg::OP_READ10: begin
               mul_a      = {16'd0, c10};
               bneed_prod = 1'b1;
            end
            sca_pkg::OP_READ12: begin
               mul_a      = c12;
               bneed_prod = 1'b1;
            end
            sca_pkg::OP_WRITE_BUFFER: begin
               // one block: block_size times one
               len_set    = 1'b1;
               mul_a      = 32'd1;
               dlen_prod  = 1'b1;
               bneed_prod = 1'b1;
            end
            sca_pkg::OP_WRITE6, sca_pkg::OP_WRITE10, sca_pkg::OP_WRITE12: begin
               if (cfg.device_is_cd) begin
                  reject = 1'b1;
               end else begin
                  len_set    = 1'b1;
                  dlen_prod  = 1'b1;
                  bneed_prod = 1'b1;
                  if (cmd.command == sca_pkg::OP_WRITE6) mul_a = {23'd0, c6};
                  else if (cmd.command == sca_pkg::OP_WRITE10) mul_a = {16'd0, c10};
                  else mul_a = c12;
               end
            end
            sca_pkg::OP_READ_CD, sca_pkg::OP_READ_CD_MSF: begin
               if (!cfg.device_is_cd) begin
                  reject = 1'b1;
               end else begin
                  mul_a      = {8'd0, cmd.cdb_byte6, c10};
                  mul_b      = sca_pkg::CD_RAW_BLOCK;
                  bneed_prod = 1'b1;
               end
            end
            sca_pkg::OP_VERIFY: begin
               fixed = 1'b1;
               if (cmd.cdb_byte1[1]) begin
                  fixed_dir  = sca_pkg::DIR_OUT;
                  mul_a      = {16'd0, c10};
                  dlen_prod  = 1'b1;
                  bneed_prod = 1'b1;
               end
            end
            sca_pkg::OP_MODE_SELECT6, sca_pkg::OP_MODE_SELECT10: begin
               if (!cfg.device_is_cd) reject = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      dec                   = '0;
      dec.cdb_length        = clen;
      dec.mul_a             = mul_a;
      dec.mul_b             = mul_b;
      if (reject) begin
         dec.reject = 1'b1;
      end else begin
         dec.dlen_from_prod  = dlen_prod;
         dec.bneed_from_prod = bneed_prod;
         if (fixed) begin
            dec.direction = fixed_dir;
         end else begin
            dec.direction         = dir_info.direction;
            dec.direction_unknown = dir_info.unknown;
            if (len_set) begin
               dec.data_length = set_len;
            end else if (!cmd.preset_length[31]) begin
               dec.data_length = cmd.preset_length;
            end else if (clen == sca_pkg::CDB_LEN6) begin
               dec.data_length = {24'd0, cmd.cdb_byte4};
            end else begin
               dec.data_length = {16'd0, c10};
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/sca_scaler.sv
// Block-count scaling for the SCSI CDB analyzer: one 32x17 multiply with
// saturation, then result assembly. Depends on sca_pkg.
`default_nettype none

module sca_scaler (
   input  wire sca_pkg::dec_type dec,
   output sca_pkg::rsp_type      rsp
);

   logic [48:0] prod;
   logic [31:0] prod_sat;

   assign prod     = {17'd0, dec.mul_a} * {32'd0, dec.mul_b};
   assign prod_sat = (|prod[48:32]) ? 32'hffff_ffff : prod[31:0];

   always_comb begin
      rsp.accepted          = !dec.reject;
      rsp.status            = dec.reject;
      rsp.cdb_length        = dec.cdb_length;
      rsp.direction         = dec.direction;
      rsp.direction_unknown = dec.direction_unknown;
      rsp.data_length       = dec.dlen_from_prod ? prod_sat : dec.data_length;
      rsp.buffer_need       = dec.bneed_from_prod ? prod_sat : 32'd0;
      rsp.sense_key         = dec.reject ? sca_pkg::SENSE_ILLEGAL_REQUEST : 3'd0;
      rsp.sense_code        = dec.reject ? sca_pkg::ASC_ILLEGAL_FIELD : 6'd0;
   end

endmodule

`default_nettype wire

>>> hw/rtl/scsi_cdb_analyzer.sv
// SCSI CDB analyzer: input register, one pass of decode and multiply, result register.
// A word passes from the input register to the result register and then out on rsp_.
// Throughput: one word per cycle while rsp_stall is low; a stalled result backs up into the input register.
// Reset (synchronous): pipeline emptied, device_is_cd 0, block_size 512,
// legacy_ansi 0, sasi_commands_allowed 1.
`default_nettype none

module scsi_cdb_analyzer (
   input  wire         clock,
   input  wire         reset,

   input  wire         csr_write_enable,
   input  wire  [1:0]  csr_index,
   input  wire  [16:0] csr_write_data,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_command,
   input  wire  [7:0]  req_cdb_byte1,
   input  wire  [7:0]  req_cdb_byte4,
   input  wire  [7:0]  req_cdb_byte6,
   input  wire  [7:0]  req_cdb_byte7,
   input  wire  [7:0]  req_cdb_byte8,
   input  wire  [7:0]  req_cdb_byte9,
   input  wire  [31:0] req_preset_length,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_status,
   output logic [4:0]  rsp_cdb_length,
   output logic [1:0]  rsp_direction,
   output logic        rsp_direction_unknown,
   output logic [31:0] rsp_data_length,
   output logic [31:0] rsp_buffer_need,
   output logic [2:0]  rsp_sense_key,
   output logic [5:0]  rsp_sense_code
);

   sca_pkg::cfg_type cfg_ff;
   sca_pkg::req_type req_ff;
   sca_pkg::rsp_type rsp_ff;
   sca_pkg::dec_type dec_in;
   sca_pkg::rsp_type rsp_in;
   logic             v1_ff, v2_ff;
   logic             adv1, adv2;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_is_cd          <= 1'b0;
         cfg_ff.block_size            <= sca_pkg::BLOCK_SIZE_RESET;
         cfg_ff.legacy_ansi           <= 1'b0;
         cfg_ff.sasi_commands_allowed <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sca_pkg::CSR_DEVICE_IS_CD: cfg_ff.device_is_cd <= csr_write_data[0];
            sca_pkg::CSR_BLOCK_SIZE:   cfg_ff.block_size   <= csr_write_data;
            sca_pkg::CSR_LEGACY_ANSI:  cfg_ff.legacy_ansi  <= csr_write_data[0];
            sca_pkg::CSR_SASI_ALLOWED: cfg_ff.sasi_commands_allowed <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // a stage loads when it is empty or its word moves on
   assign adv2      = !v2_ff || !rsp_stall;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         req_ff.command       <= req_command;
         req_ff.cdb_byte1     <= req_cdb_byte1;
         req_ff.cdb_byte4     <= req_cdb_byte4;
         req_ff.cdb_byte6     <= req_cdb_byte6;
         req_ff.cdb_byte7     <= req_cdb_byte7;
         req_ff.cdb_byte8     <= req_cdb_byte8;
         req_ff.cdb_byte9     <= req_cdb_byte9;
         req_ff.preset_length <= req_preset_length;
      end
      if (adv2 && v1_ff) rsp_ff <= rsp_in;
   end

   sca_decoder u_decoder (
      .cmd (req_ff),
      .cfg (cfg_ff),
      .dec (dec_in)
   );

   sca_scaler u_scaler (
      .dec (dec_in),
      .rsp (rsp_in)
   );

   assign rsp_valid             = v2_ff;
   assign rsp_accepted          = rsp_ff.accepted;
   assign rsp_status            = rsp_ff.status;
   assign rsp_cdb_length        = rsp_ff.cdb_length;
   assign rsp_direction         = rsp_ff.direction;
   assign rsp_direction_unknown = rsp_ff.direction_unknown;
   assign rsp_data_length       = rsp_ff.data_length;
   assign rsp_buffer_need       = rsp_ff.buffer_need;
   assign rsp_sense_key         = rsp_ff.sense_key;
   assign rsp_sense_code        = rsp_ff.sense_code;

endmodule

`default_nettype wire

>>> hw/rtl/sca_checker.sv
// Port-level checks for the SCSI CDB analyzer, bound to the top level.
// Depends on sca_pkg and scsi_cdb_analyzer_defines.svh.
`default_nettype none
`include "scsi_cdb_analyzer_defines.svh"

module sca_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_accepted,
   input wire        rsp_status,
   input wire [4:0]  rsp_cdb_length,
   input wire [1:0]  rsp_direction,
   input wire        rsp_direction_unknown,
   input wire [31:0] rsp_data_length,
   input wire [31:0] rsp_buffer_need,
   input wire [2:0]  rsp_sense_key,
   input wire [5:0]  rsp_sense_code
);

   `SCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data_length) && $stable(rsp_buffer_need),
      "stalled result word changed")

   `SCA_ASSERT_NOW(a_good_status, clock, reset, rsp_valid && rsp_accepted,
      !rsp_status && rsp_sense_key == 3'd0 && rsp_sense_code == 6'd0,
      "accepted command with nonzero status or sense")

   `SCA_ASSERT_NOW(a_reject_clean, clock, reset, rsp_valid && !rsp_accepted,
      rsp_status && rsp_data_length == 32'd0 && rsp_buffer_need == 32'd0 &&
      rsp_direction == sca_pkg::DIR_NONE && !rsp_direction_unknown &&
      rsp_sense_key == sca_pkg::SENSE_ILLEGAL_REQUEST &&
      rsp_sense_code == sca_pkg::ASC_ILLEGAL_FIELD,
      "rejected command with stray fields")

   `SCA_ASSERT_NOW(a_cdb_len, clock, reset, rsp_valid,
      rsp_cdb_length == sca_pkg::CDB_LEN6 || rsp_cdb_length == sca_pkg::CDB_LEN10 ||
      rsp_cdb_length == sca_pkg::CDB_LEN12 || rsp_cdb_length == sca_pkg::CDB_LEN16,
      "illegal CDB length")

   `SCA_ASSERT_NOW(a_unknown_dir, clock, reset, rsp_valid && rsp_direction_unknown,
      rsp_direction == sca_pkg::DIR_NONE && rsp_accepted,
      "unknown opcode with a direction")

endmodule

bind scsi_cdb_analyzer sca_checker u_sca_checker (.*);

`default_nettype wire
